// ===== rtl/trq_pkg.sv =====
// ----------------------------------------------------------------------------
// trq_pkg
// shared types, command codes and status codes of the task ready queue
// ----------------------------------------------------------------------------
`default_nettype none

package trq_pkg;

  // default number of task slots
  localparam int MAX_TASKS_DEFAULT = 32;

  // field widths
  localparam int CMD_W    = 3;
  localparam int SLOT_W   = 5;
  localparam int STATUS_W = 2;
  localparam int IN_W     = 8;
  localparam int OUT_W    = 16;

  // command codes
  localparam logic [CMD_W-1:0] OP_PUSH_TAIL      = 3'd0;
  localparam logic [CMD_W-1:0] OP_PUSH_IF_ABSENT = 3'd1;
  localparam logic [CMD_W-1:0] OP_DEQUEUE        = 3'd2;
  localparam logic [CMD_W-1:0] OP_REMOVE         = 3'd3;
  localparam logic [CMD_W-1:0] OP_PUSH_HEAD      = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_QUEUED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

  // one link table entry, valid low means no task
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
  } link_t;

  // controller to datapath commands
  typedef struct packed {
    logic                capture;
    logic                set_status;
    logic [STATUS_W-1:0] status_code;
    logic                link_first;
    logic                link_second;
    logic                unlink;
    logic                load_out;
  } trq_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             ok_slot;
    logic             member;
    logic             nonempty;
    logic             out_free;
  } trq_stat_t;

endpackage : trq_pkg

`default_nettype wire

// ===== rtl/trq_ctrl.sv =====
// ----------------------------------------------------------------------------
// trq_ctrl
// sequencer that steps one queue request through decode, link writes or
// unlink, and the hand-off to the output register
// ----------------------------------------------------------------------------
`default_nettype none

module trq_ctrl
  import trq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_fire,
  input  wire trq_stat_t stat,
  output logic           in_ready,
  output trq_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_LINK1  = 3'd2;
  localparam logic [2:0] S_LINK2  = 3'd3;
  localparam logic [2:0] S_UNLINK = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.capture = 1'b1;
          state_next  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.set_status  = 1'b1;
        cmd.status_code = ST_OK;
        unique case (stat.op)
          OP_PUSH_TAIL, OP_PUSH_IF_ABSENT, OP_PUSH_HEAD: begin
            if (!stat.ok_slot) begin
              cmd.status_code = ST_MISSING;
              state_next      = S_FIN;
            end else if (stat.member) begin
              cmd.status_code = ST_QUEUED;
              state_next      = S_FIN;
            end else begin
              state_next = S_LINK1;
            end
          end
          OP_DEQUEUE: begin
            if (!stat.nonempty) begin
              cmd.status_code = ST_MISSING;
              state_next      = S_FIN;
            end else begin
              state_next = S_UNLINK;
            end
          end
          OP_REMOVE: begin
            if (!stat.member) begin
              cmd.status_code = ST_MISSING;
              state_next      = S_FIN;
            end else begin
              state_next = S_UNLINK;
            end
          end
          default: begin
            state_next = S_FIN;
          end
        endcase
      end
      S_LINK1: begin
        cmd.link_first = 1'b1;
        state_next     = S_LINK2;
      end
      S_LINK2: begin
        cmd.link_second = 1'b1;
        state_next      = S_FIN;
      end
      S_UNLINK: begin
        cmd.unlink = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule : trq_ctrl

`default_nettype wire

// ===== rtl/trq_datapath.sv =====
// ----------------------------------------------------------------------------
// trq_datapath
// head, tail and membership registers, next and prev link memories, and the
// output register of the task ready queue
// ----------------------------------------------------------------------------
`default_nettype none

module trq_datapath
  import trq_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [IN_W-1:0]  in_data,
  input  wire trq_cmd_t         cmd,
  output trq_stat_t             stat,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [OUT_W-1:0]      out_data
);

  // only slots the 5 bit field can name are ever stored
  localparam int DEPTH = (MAX_TASKS < (1 << SLOT_W)) ? MAX_TASKS : (1 << SLOT_W);
  localparam int IW    = $clog2(DEPTH);
  localparam logic [SLOT_W:0] SLOT_LIMIT = (SLOT_W + 1)'(DEPTH);

  localparam link_t NO_LINK = '{valid: 1'b0, slot: '0};

  // captured request
  logic [CMD_W-1:0]  op;
  logic [SLOT_W-1:0] slot;

  // queue state
  logic [SLOT_W-1:0] head;
  logic [SLOT_W-1:0] tail;
  logic              nonempty;
  logic [DEPTH-1:0]  in_queue;

  // link memories and their registered read data
  link_t next_mem [DEPTH];
  link_t prev_mem [DEPTH];
  link_t rd_next;
  link_t rd_prev;

  // result of the request in flight
  logic [SLOT_W-1:0]   found;
  logic                found_valid;
  logic [STATUS_W-1:0] status;

  logic              ok_slot;
  logic              is_head_push;
  logic [SLOT_W-1:0] target;

  // memory write ports
  logic              next_we;
  logic [SLOT_W-1:0] next_waddr;
  link_t             next_wdata;
  logic              prev_we;
  logic [SLOT_W-1:0] prev_waddr;
  link_t             prev_wdata;

  assign ok_slot      = {1'b0, slot} < SLOT_LIMIT;
  assign is_head_push = (op == OP_PUSH_HEAD);
  assign target       = (op == OP_DEQUEUE) ? head : slot;

  // status to the controller
  assign stat.op       = op;
  assign stat.ok_slot  = ok_slot;
  assign stat.member   = ok_slot && in_queue[slot[IW-1:0]];
  assign stat.nonempty = nonempty;
  assign stat.out_free = !out_valid || out_ready;

  // capture request fields
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op   <= in_data[CMD_W-1:0];
      slot <= in_data[CMD_W +: SLOT_W];
    end
  end

  // link memory write selection
  always_comb begin
    next_we    = 1'b0;
    next_waddr = slot;
    next_wdata = NO_LINK;
    prev_we    = 1'b0;
    prev_waddr = slot;
    prev_wdata = NO_LINK;
    if (cmd.link_first) begin
      // new member's own links
      next_we = 1'b1;
      prev_we = 1'b1;
      if (is_head_push) begin
        next_wdata = nonempty ? link_t'{valid: 1'b1, slot: head} : NO_LINK;
      end else begin
        prev_wdata = nonempty ? link_t'{valid: 1'b1, slot: tail} : NO_LINK;
      end
    end else if (cmd.link_second) begin
      // old end points back at the new member
      if (is_head_push) begin
        prev_we    = nonempty;
        prev_waddr = head;
        prev_wdata = link_t'{valid: 1'b1, slot: slot};
      end else begin
        next_we    = nonempty;
        next_waddr = tail;
        next_wdata = link_t'{valid: 1'b1, slot: slot};
      end
    end else if (cmd.unlink) begin
      // neighbors skip over the target
      next_we    = rd_prev.valid;
      next_waddr = rd_prev.slot;
      next_wdata = rd_next;
      prev_we    = rd_next.valid;
      prev_waddr = rd_next.slot;
      prev_wdata = rd_prev;
    end
  end

  // link memories
  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_waddr[IW-1:0]] <= next_wdata;
    end
    if (prev_we) begin
      prev_mem[prev_waddr[IW-1:0]] <= prev_wdata;
    end
    rd_next <= next_mem[target[IW-1:0]];
    rd_prev <= prev_mem[target[IW-1:0]];
  end

  // head, tail and membership
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      nonempty <= 1'b0;
      in_queue <= '0;
    end else if (cmd.link_second) begin
      if (is_head_push) begin
        head <= slot;
        if (!nonempty) begin
          tail <= slot;
        end
      end else begin
        tail <= slot;
        if (!nonempty) begin
          head <= slot;
        end
      end
      nonempty                <= 1'b1;
      in_queue[slot[IW-1:0]]  <= 1'b1;
    end else if (cmd.unlink) begin
      if (!rd_prev.valid) begin
        head <= rd_next.valid ? rd_next.slot : '0;
      end
      if (!rd_next.valid) begin
        tail <= rd_prev.valid ? rd_prev.slot : '0;
      end
      if (!rd_prev.valid && !rd_next.valid) begin
        nonempty <= 1'b0;
      end
      in_queue[target[IW-1:0]] <= 1'b0;
    end
  end

  // result of the request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      found       <= '0;
      found_valid <= 1'b0;
    end
    if (cmd.set_status) begin
      status <= cmd.status_code;
    end
    if (cmd.unlink) begin
      if (op == OP_DEQUEUE) begin
        found       <= target;
        found_valid <= 1'b1;
      end else begin
        found       <= rd_next.valid ? rd_next.slot : '0;
        found_valid <= rd_next.valid;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= {2'b00, status, !nonempty, (nonempty ? head : {SLOT_W{1'b0}}),
                   found_valid, found};
    end
  end

endmodule : trq_datapath

`default_nettype wire

// ===== rtl/task_ready_queue_linked_list_top.sv =====
// ----------------------------------------------------------------------------
// task_ready_queue_linked_list_top
// doubly linked ready queue of task slots with push, dequeue and remove
// ----------------------------------------------------------------------------
// latency from request accept to result valid follows the states: a push walks
// decide, link1, link2, fin; a dequeue or remove decide, unlink, fin; a rejected
// or unknown request decide, fin; fin holds until the output register is free
// one request is worked on at a time; a new one can be taken in the cycle after the
// result is loaded, as each link memory has a single write port and a registered read
// reset clears head, tail, the empty flag, membership bits and output valid
`default_nettype none

module task_ready_queue_linked_list_top
  import trq_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [IN_W-1:0]  s_tdata,   // command[2:0], task_slot[7:3]
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [OUT_W-1:0]      m_tdata    // found_task[4:0], found_valid[5],
                                           // head_task[10:6], queue_empty[11],
                                           // status[13:12], zero[15:14]
);

  trq_cmd_t  cmd;
  trq_stat_t stat;

  trq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (s_tvalid && s_tready),
    .stat     (stat),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  trq_datapath #(
    .MAX_TASKS (MAX_TASKS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule : task_ready_queue_linked_list_top

`default_nettype wire

// ===== rtl/trq_checker.sv =====
// ----------------------------------------------------------------------------
// trq_checker
// port level checks of the task ready queue, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module trq_checker
  import trq_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             s_tvalid,
  input wire logic             s_tready,
  input wire logic             m_tvalid,
  input wire logic             m_tready,
  input wire logic [OUT_W-1:0] m_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // one request at a time: ready drops after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while another is in flight");

  // empty queue reports head zero
  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[11] |-> m_tdata[10:6] == 5'd0)
    else $error("empty queue with nonzero head");

  // no found task means found field zero
  a_found_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[5] |-> m_tdata[4:0] == 5'd0)
    else $error("found task nonzero without valid");

  // a found task only comes with ok status
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[5] |-> m_tdata[13:12] == ST_OK)
    else $error("found task with error status");

endmodule : trq_checker

bind task_ready_queue_linked_list_top trq_checker u_trq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== tb/task_queue_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// task_queue_checker
// watches both stream channels of the task ready queue, predicts the result
// of every accepted request from its own copy of the linked queue and
// compares each accepted result with the oldest prediction
// ----------------------------------------------------------------------------

module task_queue_checker
  import trq_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  input  wire logic            s_tready,
  input  wire logic [IN_W-1:0] s_tdata,   // command[2:0], task_slot[7:3]
  input  wire logic            m_tvalid,
  input  wire logic            m_tready,
  input  wire logic [OUT_W-1:0] m_tdata,  // found_task[4:0], found_valid[5],
                                          // head_task[10:6], queue_empty[11],
                                          // status[13:12], zero[15:14]
  output int                   error_count,
  output int                   results_pending
);

  localparam int SLOTS = MAX_TASKS_DEFAULT;
  // a link with the top bit set points at no task
  localparam logic [SLOT_W:0] NO_LINK = (SLOT_W + 1)'(SLOTS);

  // one result, laid out as on m_tdata (msb first)
  typedef struct packed {
    logic [1:0]          pad;
    logic [STATUS_W-1:0] status;
    logic                queue_empty;
    logic [SLOT_W-1:0]   head_task;
    logic                found_valid;
    logic [SLOT_W-1:0]   found_task;
  } queue_result_t;

  // shadow queue state
  logic [SLOT_W-1:0] head_sh;
  logic [SLOT_W-1:0] tail_sh;
  logic              nonempty_sh;
  logic [SLOT_W:0]   next_sh [SLOTS];
  logic [SLOT_W:0]   prev_sh [SLOTS];
  logic              member_sh [SLOTS];

  queue_result_t expected_results[$];
  queue_result_t want;
  queue_result_t got;
  queue_result_t predicted;
  int            errors = 0;

  // append a task that is not yet queued at the tail
  task automatic link_at_tail(input logic [SLOT_W-1:0] s);
    next_sh[s] = NO_LINK;
    if (!nonempty_sh) begin
      prev_sh[s] = NO_LINK;
      head_sh = s;
    end else begin
      prev_sh[s] = {1'b0, tail_sh};
      next_sh[tail_sh] = {1'b0, s};
    end
    tail_sh = s;
    nonempty_sh = 1'b1;
    member_sh[s] = 1'b1;
  endtask

  // insert a task that is not yet queued at the head
  task automatic link_at_head(input logic [SLOT_W-1:0] s);
    prev_sh[s] = NO_LINK;
    if (!nonempty_sh) begin
      next_sh[s] = NO_LINK;
      tail_sh = s;
    end else begin
      next_sh[s] = {1'b0, head_sh};
      prev_sh[head_sh] = {1'b0, s};
    end
    head_sh = s;
    nonempty_sh = 1'b1;
    member_sh[s] = 1'b1;
  endtask

  // take a queued task out, hand back its successor link
  task automatic unlink_member(input logic [SLOT_W-1:0] s, output logic [SLOT_W:0] succ);
    logic [SLOT_W:0] nx;
    logic [SLOT_W:0] pv;
    nx = next_sh[s];
    pv = prev_sh[s];
    if (!pv[SLOT_W]) next_sh[pv[SLOT_W-1:0]] = nx;
    else head_sh = nx[SLOT_W] ? '0 : nx[SLOT_W-1:0];
    if (!nx[SLOT_W]) prev_sh[nx[SLOT_W-1:0]] = pv;
    else tail_sh = pv[SLOT_W] ? '0 : pv[SLOT_W-1:0];
    if (pv[SLOT_W] && nx[SLOT_W]) nonempty_sh = 1'b0;
    next_sh[s] = NO_LINK;
    prev_sh[s] = NO_LINK;
    member_sh[s] = 1'b0;
    succ = nx;
  endtask

  // carry out one request on the shadow queue and form its result
  task automatic predict_queue_op(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] s,
                                  output queue_result_t r);
    logic [SLOT_W:0] succ;
    r = '0;
    r.status = ST_OK;
    case (cmd)
      OP_PUSH_TAIL, OP_PUSH_IF_ABSENT, OP_PUSH_HEAD: begin
        if (member_sh[s]) r.status = ST_QUEUED;
        else if (cmd == OP_PUSH_HEAD) link_at_head(s);
        else link_at_tail(s);
      end
      OP_DEQUEUE: begin
        if (!nonempty_sh) begin
          r.status = ST_MISSING;
        end else begin
          r.found_task = head_sh;
          r.found_valid = 1'b1;
          unlink_member(head_sh, succ);
        end
      end
      OP_REMOVE: begin
        if (!member_sh[s]) begin
          r.status = ST_MISSING;
        end else begin
          unlink_member(s, succ);
          // removing the tail leaves no successor to report
          if (!succ[SLOT_W]) begin
            r.found_task = succ[SLOT_W-1:0];
            r.found_valid = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.head_task = nonempty_sh ? head_sh : '0;
    r.queue_empty = !nonempty_sh;
  endtask

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
               act_val);
      errors++;
    end
  endtask

  // result compare first, then prediction of the request taken at this edge
  always @(posedge clk) begin
    if (rst) begin
      head_sh = '0;
      tail_sh = '0;
      nonempty_sh = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        next_sh[i] = NO_LINK;
        prev_sh[i] = NO_LINK;
        member_sh[i] = 1'b0;
      end
      expected_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_results.size() == 0) begin
          $display("%0t ns: result with none expected, expected none, actual %h", $time,
                   m_tdata);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("found_task", int'(want.found_task), int'(got.found_task));
          check_field("found_valid", int'(want.found_valid), int'(got.found_valid));
          check_field("head_task", int'(want.head_task), int'(got.head_task));
          check_field("queue_empty", int'(want.queue_empty), int'(got.queue_empty));
          check_field("status", int'(want.status), int'(got.status));
          check_field("padding", int'(want.pad), int'(got.pad));
        end
      end
      if (s_tvalid && s_tready) begin
        predict_queue_op(s_tdata[CMD_W-1:0], s_tdata[CMD_W +: SLOT_W], predicted);
        expected_results.push_back(predicted);
      end
    end
    results_pending <= expected_results.size();
    error_count <= errors;
  end

endmodule : task_queue_checker

// ===== tb/task_ready_queue_linked_list_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// task_ready_queue_linked_list_top_tb
// drives push, dequeue and remove requests into the task ready queue: a
// directed opening over the corner cases, then random requests in phases of
// sender idling and receiver stalling; a separate checker predicts and
// compares every result
// ----------------------------------------------------------------------------

module task_ready_queue_linked_list_top_tb;
  import trq_pkg::*;

  localparam int ITEMS_PER_PHASE   = 460;
  localparam int MODE_SPAN         = 64;    // requests per fill or drain stretch
  localparam int LONG_STALL_CYCLES = 300;
  localparam int DRAIN_CYCLES      = 10;
  localparam int WATCHDOG_LIMIT    = 3000;

  // command codes the block does not know
  localparam logic [CMD_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [CMD_W-1:0] OP_UNUSED_HI = 3'd7;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic long_stall_req = 1'b0;
  int   error_count;
  int   results_pending;
  int   quiet_cycles = 0;

  task_ready_queue_linked_list_top #(
    .MAX_TASKS(MAX_TASKS_DEFAULT)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  task_queue_checker queue_check (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .error_count    (error_count),
    .results_pending(results_pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // offer one request after a random idle gap, return once it is taken
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {slot, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  // fill stretches favor pushes, drain stretches favor dequeue and remove
  task automatic send_random_request(input bit filling);
    logic [CMD_W-1:0] cmd;
    int               pick;
    pick = $urandom_range(99);
    if (filling) begin
      if (pick < 30) cmd = OP_PUSH_TAIL;
      else if (pick < 50) cmd = OP_PUSH_IF_ABSENT;
      else if (pick < 70) cmd = OP_PUSH_HEAD;
      else if (pick < 85) cmd = OP_REMOVE;
      else if (pick < 95) cmd = OP_DEQUEUE;
      else cmd = CMD_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
    end else begin
      if (pick < 8) cmd = OP_PUSH_TAIL;
      else if (pick < 14) cmd = OP_PUSH_IF_ABSENT;
      else if (pick < 20) cmd = OP_PUSH_HEAD;
      else if (pick < 55) cmd = OP_REMOVE;
      else if (pick < 95) cmd = OP_DEQUEUE;
      else cmd = CMD_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
    end
    send_request(cmd, SLOT_W'($urandom_range(MAX_TASKS_DEFAULT - 1)));
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input bit with_hold_off);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    if (with_hold_off) long_stall_req <= 1'b1;
    for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
      send_random_request(((n / MODE_SPAN) % 2) == 0);
    end
    wait_drained();
  endtask

  // result side, with a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (long_stall_req) begin
        m_tready <= 1'b0;
        repeat (LONG_STALL_CYCLES) @(posedge clk);
        long_stall_req <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus and verdict
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed corner cases
    send_request(OP_DEQUEUE, 5'd0);         // dequeue on empty
    send_request(OP_REMOVE, 5'd3);          // remove from empty
    send_request(OP_PUSH_TAIL, 5'd0);
    send_request(OP_PUSH_TAIL, 5'd31);
    send_request(OP_PUSH_TAIL, 5'd0);       // already queued
    send_request(OP_PUSH_IF_ABSENT, 5'd31); // already queued
    send_request(OP_PUSH_IF_ABSENT, 5'd10);
    send_request(OP_PUSH_HEAD, 5'd21);
    send_request(OP_PUSH_HEAD, 5'd21);      // already queued
    send_request(OP_PUSH_HEAD, 5'd31);      // already queued
    send_request(OP_REMOVE, 5'd10);         // remove the tail
    send_request(OP_REMOVE, 5'd0);          // remove from the middle
    send_request(OP_REMOVE, 5'd5);          // not queued
    send_request(OP_UNUSED_LO, 5'd31);
    send_request(OP_UNUSED_LO + 3'd1, 5'd0);
    send_request(OP_UNUSED_HI, 5'd21);
    send_request(OP_DEQUEUE, 5'd0);
    send_request(OP_DEQUEUE, 5'd31);
    send_request(OP_DEQUEUE, 5'd0);         // empty again
    send_request(OP_PUSH_HEAD, 5'd31);      // insert at head of empty queue
    send_request(OP_REMOVE, 5'd31);         // remove the only member
    send_request(OP_PUSH_TAIL, 5'd7);
    send_request(OP_DEQUEUE, 5'd31);
    send_request(OP_DEQUEUE, 5'd31);
    wait_drained();

    // random phases: none, sender idle, receiver stall, both
    run_phase(0, 0, 1'b1);
    run_phase(83, 0, 1'b0);
    run_phase(0, 83, 1'b0);
    run_phase(20, 20, 1'b0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule : task_ready_queue_linked_list_top_tb
